// ===== rtl/core/bppw_pkg.sv =====
// ----------------------------------------------------------------------------
// bppw_pkg: shared types and constants for the brush point pixel writer
// Widths, configuration register codes, pixel formats, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bppw_pkg;

  // Field widths
  localparam int unsigned COORD_BITS_DEF = 13;
  localparam int unsigned DIM_W          = 13;
  localparam int unsigned BRUSH_W        = 4;
  localparam int unsigned LAYER_W        = 2;
  localparam int unsigned INDEX_W        = 24;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned FMT_W          = 2;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 32;

  // Brush size clamp and number of layer buffers
  localparam int unsigned MAX_BRUSH      = 8;
  localparam int unsigned LAYERS         = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB_WIDTH   = 3'd0,
    REG_FB_HEIGHT  = 3'd1,
    REG_OFFSET_X   = 3'd2,
    REG_OFFSET_Y   = 3'd3,
    REG_PIX_FORMAT = 3'd4,
    REG_FG_COLOR   = 3'd5,
    REG_WIN_WIDTH  = 3'd6,
    REG_WIN_HEIGHT = 3'd7
  } cfg_reg_e;

  // Pixel formats
  typedef enum logic [FMT_W-1:0] {
    FMT_8BPP  = 2'd0,
    FMT_15BPP = 2'd1,
    FMT_16BPP = 2'd2,
    FMT_32BPP = 2'd3
  } pix_fmt_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_WALK  = 2'd1,
    ST_FLUSH = 2'd2
  } ctrl_state_e;

  // Configuration register set
  typedef struct packed {
    logic [DIM_W-1:0]        fb_width;
    logic [DIM_W-1:0]        fb_height;
    logic signed [DIM_W-1:0] offset_x;
    logic signed [DIM_W-1:0] offset_y;
    pix_fmt_e                pixel_format;
    logic [DATA_W-1:0]       fg_color;
    logic [DIM_W-1:0]        win_width;
    logic [DIM_W-1:0]        win_height;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fb_width:     DIM_W'(640),
    fb_height:    DIM_W'(480),
    offset_x:     '0,
    offset_y:     '0,
    pixel_format: FMT_32BPP,
    fg_color:     '0,
    win_width:    DIM_W'(640),
    win_height:   DIM_W'(480)
  };

  // Controller -> datapath
  typedef struct packed {
    logic load;   // latch a new point
    logic step;   // visit the current brush pixel and advance
    logic flush;  // move the held write out, marked last
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic empty;      // brush covers no pixel
    logic hit;        // current pixel lies inside the framebuffer
    logic last_pix;   // current pixel ends the walk
    logic pend_valid; // a write is held back waiting for its last flag
    logic out_free;   // output register can take a write this cycle
  } dp_status_t;

  // Foreground color trimmed to the active format
  function automatic logic [DATA_W-1:0] color_word(pix_fmt_e fmt, logic [DATA_W-1:0] c);
    logic [DATA_W-1:0] r;
    unique case (fmt)
      FMT_8BPP:  r = {24'h0, c[7:0]};
      FMT_15BPP: r = {17'h0, c[14:0]};
      FMT_16BPP: r = {16'h0, c[15:0]};
      default:   r = c;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/bppw_point_if.sv =====
// ----------------------------------------------------------------------------
// bppw_point_if: point input channel
// Valid/ready channel carrying one brush point per transaction.
// ----------------------------------------------------------------------------
interface bppw_point_if #(
  parameter int unsigned COORD_BITS = bppw_pkg::COORD_BITS_DEF
);
  import bppw_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic [BRUSH_W-1:0]           brush_w;
  logic [BRUSH_W-1:0]           brush_h;
  logic [LAYER_W-1:0]           layer;

  modport source (output valid, pos_x, pos_y, brush_w, brush_h, layer, input ready);
  modport sink   (input valid, pos_x, pos_y, brush_w, brush_h, layer, output ready);
endinterface

// ===== rtl/core/bppw_write_if.sv =====
// ----------------------------------------------------------------------------
// bppw_write_if: framebuffer write channel
// Valid/ready channel carrying one pixel write per transaction.
// ----------------------------------------------------------------------------
interface bppw_write_if;
  import bppw_pkg::*;

  logic               valid;
  logic               ready;
  logic [LAYER_W-1:0] out_layer;
  logic [INDEX_W-1:0] pixel_index;
  logic [DATA_W-1:0]  pixel_data;
  logic [FMT_W-1:0]   write_format;
  logic               last;

  modport source (output valid, out_layer, pixel_index, pixel_data, write_format, last,
                  input ready);
  modport sink   (input valid, out_layer, pixel_index, pixel_data, write_format, last,
                  output ready);
endinterface

// ===== rtl/core/bppw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bppw_cfg_regs: configuration register file
// Write-only registers for framebuffer geometry, offset, format, color and window size.
// ----------------------------------------------------------------------------
module bppw_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bppw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bppw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output bppw_pkg::cfg_t                 cfg_o
);
  import bppw_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_FB_WIDTH:   cfg_d.fb_width     = cfg_data_i[DIM_W-1:0];
        REG_FB_HEIGHT:  cfg_d.fb_height    = cfg_data_i[DIM_W-1:0];
        REG_OFFSET_X:   cfg_d.offset_x     = $signed(cfg_data_i[DIM_W-1:0]);
        REG_OFFSET_Y:   cfg_d.offset_y     = $signed(cfg_data_i[DIM_W-1:0]);
        REG_PIX_FORMAT: cfg_d.pixel_format = pix_fmt_e'(cfg_data_i[FMT_W-1:0]);
        REG_FG_COLOR:   cfg_d.fg_color     = cfg_data_i[DATA_W-1:0];
        REG_WIN_WIDTH:  cfg_d.win_width    = cfg_data_i[DIM_W-1:0];
        REG_WIN_HEIGHT: cfg_d.win_height   = cfg_data_i[DIM_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/bppw_ctrl.sv =====
// ----------------------------------------------------------------------------
// bppw_ctrl: point walk controller
// Accepts a point, steps the datapath over the brush pixels, then flushes the
// held write, if any, with its last flag before returning to idle.
// ----------------------------------------------------------------------------
module bppw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bppw_pkg::dp_status_t status_i,
  output bppw_pkg::dp_cmd_t    cmd_o
);
  import bppw_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        can_step;

  // A hit with a write already held needs the output register
  assign can_step = !(status_i.hit && status_i.pend_valid) || status_i.out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (status_i.empty) begin
          state_d = ST_FLUSH;
        end else if (can_step && status_i.last_pix) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status_i.pend_valid || status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_WALK: begin
        cmd_o.step = !status_i.empty && can_step;
      end
      ST_FLUSH: begin
        cmd_o.flush = status_i.pend_valid && status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/bppw_datapath.sv =====
// ----------------------------------------------------------------------------
// bppw_datapath: brush walk counters, clipping, index and output register
// Holds the column/row counters, clips each pixel, forms y*stride+x, keeps
// one write back until the next hit or the end decides its last flag.
// ----------------------------------------------------------------------------
module bppw_datapath #(
  parameter int unsigned COORD_BITS = bppw_pkg::COORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bppw_pkg::cfg_t                  cfg_i,
  input  bppw_pkg::dp_cmd_t               cmd_i,
  output bppw_pkg::dp_status_t            status_o,
  input  logic signed [COORD_BITS-1:0]    pos_x_i,
  input  logic signed [COORD_BITS-1:0]    pos_y_i,
  input  logic [bppw_pkg::BRUSH_W-1:0]    brush_w_i,
  input  logic [bppw_pkg::BRUSH_W-1:0]    brush_h_i,
  input  logic [bppw_pkg::LAYER_W-1:0]    layer_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bppw_pkg::LAYER_W-1:0]    out_layer_o,
  output logic [bppw_pkg::INDEX_W-1:0]    pixel_index_o,
  output logic [bppw_pkg::DATA_W-1:0]     pixel_data_o,
  output logic [bppw_pkg::FMT_W-1:0]      write_format_o,
  output logic                            last_o
);
  import bppw_pkg::*;

  // Coordinate width: point range plus brush and offset headroom
  localparam int unsigned CW     = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 3;
  localparam int unsigned PROD_W = 2 * DIM_W;

  // Walk registers
  logic signed [CW-1:0] x_q, y_q, ys_q, xend_q, yend_q;
  logic [LAYER_W-1:0]   lay_q;
  logic                 pend_valid_q;
  logic [INDEX_W-1:0]   pend_idx_q;

  // Output register
  logic                 out_valid_q;
  logic [LAYER_W-1:0]   out_layer_q;
  logic [INDEX_W-1:0]   out_idx_q;
  logic [DATA_W-1:0]    out_data_q;
  logic [FMT_W-1:0]     out_fmt_q;
  logic                 out_last_q;

  // Point setup
  logic [BRUSH_W-1:0]   bw_sat, bh_sat;
  logic                 wide;
  logic signed [CW-1:0] px_ext, py_ext;
  logic signed [CW-1:0] half_w, half_h, full_w, full_h;
  logic signed [CW-1:0] xs_d, ys_d, xend_d, yend_d;
  logic [LAYER_W-1:0]   lay_sat;

  assign bw_sat = (brush_w_i > BRUSH_W'(MAX_BRUSH)) ? BRUSH_W'(MAX_BRUSH) : brush_w_i;
  assign bh_sat = (brush_h_i > BRUSH_W'(MAX_BRUSH)) ? BRUSH_W'(MAX_BRUSH) : brush_h_i;
  assign wide   = bw_sat > BRUSH_W'(1);
  assign px_ext = CW'(pos_x_i);
  assign py_ext = CW'(pos_y_i);
  assign half_w = $signed(CW'(bw_sat >> 1));
  assign half_h = $signed(CW'(bh_sat >> 1));
  assign full_w = $signed(CW'(bw_sat));
  assign full_h = $signed(CW'(bh_sat));

  // Wide brush: centered on the point, forward extent halved
  assign xs_d   = wide ? (px_ext - half_w) : px_ext;
  assign ys_d   = wide ? (py_ext - half_h) : py_ext;
  assign xend_d = px_ext + (wide ? half_w : full_w);
  assign yend_d = py_ext + (wide ? half_h : full_h);
  assign lay_sat = (int'(layer_i) >= int'(LAYERS)) ? LAYER_W'(LAYERS - 1) : layer_i;

  // Walk advance and window stop
  logic signed [CW-1:0] x1, y1, winw, winh;
  logic                 col_end, row_end;

  assign x1      = x_q + CW'(1);
  assign y1      = y_q + CW'(1);
  assign winw    = $signed(CW'(cfg_i.win_width));
  assign winh    = $signed(CW'(cfg_i.win_height));
  assign col_end = (y1 >= yend_q) || (y1 >= winh);
  assign row_end = (x1 >= xend_q) || (x1 >= winw);

  // Offset, clip and pixel index
  logic signed [CW-1:0] sx, sy;
  logic [CW-1:0]        fbw_ext, fbh_ext;
  logic                 hit;
  logic [PROD_W-1:0]    prod, idx_sum;

  assign sx      = x_q + CW'($signed(cfg_i.offset_x));
  assign sy      = y_q + CW'($signed(cfg_i.offset_y));
  assign fbw_ext = CW'(cfg_i.fb_width);
  assign fbh_ext = CW'(cfg_i.fb_height);
  assign hit     = !sx[CW-1] && !sy[CW-1] &&
                   ($unsigned(sx) < fbw_ext) && ($unsigned(sy) < fbh_ext);
  assign prod    = PROD_W'(sy[DIM_W-1:0]) * PROD_W'(cfg_i.fb_width);
  assign idx_sum = prod + PROD_W'(sx[DIM_W-1:0]);

  // Write movement
  logic pend_load, push_mid, push;

  assign pend_load = cmd_i.step && hit;
  assign push_mid  = pend_load && pend_valid_q;
  assign push      = push_mid || cmd_i.flush;

  // Status to controller
  assign status_o.empty      = (x_q >= xend_q) || (ys_q >= yend_q);
  assign status_o.hit        = hit;
  assign status_o.last_pix   = col_end && row_end;
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Counters and point registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= xs_d;
      y_q    <= ys_d;
      ys_q   <= ys_d;
      xend_q <= xend_d;
      yend_q <= yend_d;
      lay_q  <= lay_sat;
    end else if (cmd_i.step) begin
      if (col_end) begin
        x_q <= x1;
        y_q <= ys_q;
      end else begin
        y_q <= y1;
      end
    end
    if (pend_load) pend_idx_q <= idx_sum[INDEX_W-1:0];
  end

  // Held write flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (pend_load) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.flush) begin
      pend_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      out_layer_q <= lay_q;
      out_idx_q   <= pend_idx_q;
      out_data_q  <= color_word(cfg_i.pixel_format, cfg_i.fg_color);
      out_fmt_q   <= cfg_i.pixel_format;
      out_last_q  <= cmd_i.flush;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_layer_o    = out_layer_q;
  assign pixel_index_o  = out_idx_q;
  assign pixel_data_o   = out_data_q;
  assign write_format_o = out_fmt_q;
  assign last_o         = out_last_q;

endmodule

// ===== rtl/core/brush_point_pixel_writer_core.sv =====
// Write release: a write is held until the next hit is visited and leaves at
//   the edge ending that visit; the last write leaves from the flush state.
// Throughput: brush pixels are visited one per cycle through the single
//   clip/index stage, stalling while a hit finds the output register busy;
//   a new point is accepted only after the previous point is flushed.
// Reset: rst_ni asynchronous active low; controller idle, no write held,
//   configuration back to 640x480, no offset, 32-bit format, color 0.
// ----------------------------------------------------------------------------
// brush_point_pixel_writer_core: brush point plot with clipping
// Walks the brush column by column, clips each pixel against the framebuffer
// and emits one pixel write per surviving pixel.
// ----------------------------------------------------------------------------
module brush_point_pixel_writer_core #(
  parameter int unsigned COORD_BITS = bppw_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  bppw_point_if.sink                       point_i,
  bppw_write_if.source                     write_o,
  input  logic                             cfg_we_i,
  input  logic [bppw_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bppw_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import bppw_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // Configuration registers
  bppw_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Controller
  bppw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (point_i.valid),
    .in_ready_o (point_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  bppw_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .status_o       (status),
    .pos_x_i        (point_i.pos_x),
    .pos_y_i        (point_i.pos_y),
    .brush_w_i      (point_i.brush_w),
    .brush_h_i      (point_i.brush_h),
    .layer_i        (point_i.layer),
    .out_valid_o    (write_o.valid),
    .out_ready_i    (write_o.ready),
    .out_layer_o    (write_o.out_layer),
    .pixel_index_o  (write_o.pixel_index),
    .pixel_data_o   (write_o.pixel_data),
    .write_format_o (write_o.write_format),
    .last_o         (write_o.last)
  );

endmodule

// ===== rtl/core/bppw_checker.sv =====
// ----------------------------------------------------------------------------
// bppw_checker: port-level checks for the brush point pixel writer
// Watches the point and write channels; bound onto the core.
// ----------------------------------------------------------------------------
module bppw_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [bppw_pkg::LAYER_W-1:0]   out_layer_i,
  input logic [bppw_pkg::INDEX_W-1:0]   pixel_index_i,
  input logic [bppw_pkg::DATA_W-1:0]    pixel_data_i,
  input logic [bppw_pkg::FMT_W-1:0]     write_format_i,
  input logic                           last_i
);

  // A stalled write keeps its valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("write valid dropped while stalled");

  // A stalled write keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(pixel_index_i) && $stable(out_layer_i) && $stable(pixel_data_i) &&
      $stable(write_format_i) && $stable(last_i))
    else $error("write payload changed while stalled");

  // One point at a time: ready drops after a point transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("point accepted while previous point in progress");

  // While idle no new write is produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && !(out_valid_i && !out_ready_i) |=> !out_valid_i)
    else $error("write produced while idle");

endmodule

bind brush_point_pixel_writer_core bppw_checker u_bppw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (point_i.valid),
  .in_ready_i     (point_i.ready),
  .out_valid_i    (write_o.valid),
  .out_ready_i    (write_o.ready),
  .out_layer_i    (write_o.out_layer),
  .pixel_index_i  (write_o.pixel_index),
  .pixel_data_i   (write_o.pixel_data),
  .write_format_i (write_o.write_format),
  .last_i         (write_o.last)
);
